@@ rtl/ssr_pkg.sv @@
// shared constants, statistic codes and unit request/response types for the statistic reducer
`default_nettype none
package ssr_pkg;
    localparam int unsigned MAX_COUNT  = 65536;
    localparam int unsigned CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned MEAN_GUARD = 16;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [3:0] STAT_MEAN    = 4'd0;
    localparam logic [3:0] STAT_SUM     = 4'd1;
    localparam logic [3:0] STAT_PRODUCT = 4'd2;
    localparam logic [3:0] STAT_RMS     = 4'd3;
    localparam logic [3:0] STAT_NORM    = 4'd4;
    localparam logic [3:0] STAT_VAR     = 4'd5;
    localparam logic [3:0] STAT_STD     = 4'd6;
    localparam logic [3:0] STAT_MIN     = 4'd7;
    localparam logic [3:0] STAT_MAX     = 4'd8;
    localparam logic [3:0] STAT_ABSMAX  = 4'd9;
    localparam logic [3:0] STAT_MAGMAX  = 4'd10;

    // right shift applied after a product
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_FRAC = 2'd1;
    localparam logic [1:0] SH_WIDE = 2'd2;

    typedef struct packed {
        logic        start;
        logic [63:0] num_mag;
        logic [32:0] den;
        logic        neg;
    } t_div_req;

    typedef struct packed {
        logic        start;
        logic [63:0] a_mag;
        logic [63:0] b_mag;
        logic [1:0]  shift;
        logic        neg;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } t_sqrt_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
    } t_unit_rsp;

    typedef struct packed {
        logic        done;
        logic [32:0] root;
    } t_sqrt_rsp;
endpackage
`default_nettype wire

@@ rtl/ssr_in_if.sv @@
// sample channel: valid/ready handshake with sample, finite and last flags
`default_nettype none
interface ssr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               sample_finite;
    logic               last_sample;

    modport source (output valid, output sample, output sample_finite, output last_sample,
                    input ready);
    modport sink   (input valid, input sample, input sample_finite, input last_sample,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/ssr_out_if.sv @@
// result channel: valid/ready handshake with the statistic and its nan flag
`default_nettype none
interface ssr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               result_is_nan;

    modport source (output valid, output result_value, output result_is_nan, input ready);
    modport sink   (input valid, input result_value, input result_is_nan, output ready);
endinterface
`default_nettype wire

@@ rtl/ssr_div.sv @@
// iterative rounded divider, two quotient bits per cycle
`default_nettype none
module ssr_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssr_pkg::t_div_req i_req,
    output ssr_pkg::t_unit_rsp     o_rsp
);
    logic               r_busy;
    logic               r_done;
    logic [5:0]         r_cnt;
    logic [65:0]        r_dvd;
    logic [33:0]        r_rem;
    logic [65:0]        r_quo;
    logic [32:0]        r_den;
    logic               r_neg;
    logic signed [63:0] r_val;

    logic [65:0]        n_dvd;
    logic [33:0]        n_rem;
    logic [65:0]        n_quo;
    logic [63:0]        q_sat;
    logic signed [63:0] n_val;

    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int i = 0; i < 2; i++) begin
            n_rem = {n_rem[32:0], n_dvd[65]};
            n_dvd = {n_dvd[64:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem = n_rem - {1'b0, r_den};
                n_quo = {n_quo[64:0], 1'b1};
            end else begin
                n_quo = {n_quo[64:0], 1'b0};
            end
        end
    end

    assign q_sat = (|r_quo[65:63]) ? ssr_pkg::S64_MAX : r_quo[63:0];
    assign n_val = r_neg ? -$signed(q_sat) : $signed(q_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                // rounding: add half the divisor before dividing
                r_dvd  <= {1'b0, {1'b0, i_req.num_mag} + 65'(i_req.den >> 1)};
                r_rem  <= '0;
                r_quo  <= '0;
                r_den  <= i_req.den;
                r_neg  <= i_req.neg;
            end else if (r_busy) begin
                if (r_cnt != 6'd0) begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - 6'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_val  <= n_val;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;
endmodule
`default_nettype wire

@@ rtl/ssr_mul.sv @@
// 64x64 magnitude multiplier over four 32x32 partial products, rounded shift and saturation
`default_nettype none
module ssr_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssr_pkg::t_mul_req i_req,
    output ssr_pkg::t_unit_rsp     o_rsp
);
    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_step;
    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic [1:0]         r_sh;
    logic               r_neg;
    logic [63:0]        r_pp;
    logic [127:0]       r_acc;
    logic signed [63:0] r_val;

    logic [1:0]         pk;
    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [127:0]       pp_sh;
    logic [127:0]       rnd_sum;
    logic [127:0]       shifted;
    logic [63:0]        mag;
    logic signed [63:0] n_val;

    assign a_half = r_step[0] ? r_a[63:32] : r_a[31:0];
    assign b_half = r_step[1] ? r_b[63:32] : r_b[31:0];
    assign pk     = 2'(r_step - 3'd1);

    always_comb begin
        unique case (pk)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1,
            2'd2:    pp_sh = {32'd0, r_pp, 32'd0};
            default: pp_sh = {r_pp, 64'd0};
        endcase
    end

    always_comb begin
        unique case (r_sh)
            ssr_pkg::SH_FRAC: begin
                rnd_sum = r_acc + (128'd1 << (ssr_pkg::FRAC_BITS - 1));
                shifted = rnd_sum >> ssr_pkg::FRAC_BITS;
            end
            ssr_pkg::SH_WIDE: begin
                rnd_sum = r_acc + (128'd1 << (2 * ssr_pkg::MEAN_GUARD - 1));
                shifted = rnd_sum >> (2 * ssr_pkg::MEAN_GUARD);
            end
            default: begin
                rnd_sum = r_acc;
                shifted = r_acc;
            end
        endcase
        mag   = (|shifted[127:63]) ? ssr_pkg::S64_MAX : shifted[63:0];
        n_val = r_neg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_a    <= i_req.a_mag;
                r_b    <= i_req.b_mag;
                r_sh   <= i_req.shift;
                r_neg  <= i_req.neg;
                r_acc  <= '0;
            end else if (r_busy) begin
                // product of this step, accumulate the one from the step before
                if (r_step <= 3'd3) begin
                    r_pp <= a_half * b_half;
                end
                if (r_step >= 3'd1 && r_step <= 3'd4) begin
                    r_acc <= r_acc + pp_sh;
                end
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_val  <= n_val;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;
endmodule
`default_nettype wire

@@ rtl/ssr_sqrt.sv @@
// bit-serial rounded integer square root, one result bit per cycle
`default_nettype none
module ssr_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ssr_pkg::t_sqrt_req i_req,
    output ssr_pkg::t_sqrt_rsp      o_rsp
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [32:0] r_root;

    logic [63:0] trial;
    logic [63:0] n_v;
    logic [63:0] n_r;

    always_comb begin
        trial = r_r + r_bit;
        if (r_v >= trial) begin
            n_v = r_v - trial;
            n_r = (r_r >> 1) + r_bit;
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_v    <= i_req.x;
                r_r    <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_cnt != 6'd0) begin
                    r_v   <= n_v;
                    r_r   <= n_r;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 6'd1;
                end else begin
                    // remainder above the root means rounding up
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_root <= (r_v > r_r) ? 33'(r_r[31:0]) + 33'd1 : 33'(r_r[31:0]);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;
endmodule
`default_nettype wire

@@ rtl/streaming_statistic_reducer_top.sv @@
// streaming statistic reducer: sequencer, accumulators and output register
// Usage: samples arrive on i_in (valid/ready) as Q16.16 values with a finite flag
// and a last flag. A non-finite sample is skipped. The beat marked last closes the
// traversal and one result beat (value, nan flag) leaves on o_out.
// i_cfg_we/i_cfg_wdata set the statistic code; write it only while the block idles.
// Throughput: one sample at a time. Mean, sum and extremes update directly;
// product and sum of squares take one pass of the four-pass multiplier, variance and
// std a divider pass at two quotient bits a cycle, then one multiplier pass.
// The last beat adds the final step (a divide, a square root, or a divide then a
// square root) before the result beat is valid.
// The result waits in an output register; a new traversal is taken meanwhile and
// only its own last beat waits for the receiver to take the earlier result.
// Reset (synchronous, active low) clears all accumulators and sets the statistic
// to mean. After each result the accumulators return to their reset values.
`default_nettype none
module streaming_statistic_reducer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata,
    ssr_in_if.sink          i_in,
    ssr_out_if.source       o_out
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_UPD    = 4'd1;
    localparam logic [3:0] ST_PROD   = 4'd2;
    localparam logic [3:0] ST_SQS    = 4'd3;
    localparam logic [3:0] ST_WDIV   = 4'd4;
    localparam logic [3:0] ST_WSTART = 4'd5;
    localparam logic [3:0] ST_WMUL   = 4'd6;
    localparam logic [3:0] ST_FIN    = 4'd7;
    localparam logic [3:0] ST_FDIV   = 4'd8;
    localparam logic [3:0] ST_FSQRT  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam int unsigned CW = ssr_pkg::CNT_W;

    logic [3:0]         r_stat;
    logic [3:0]         r_state;
    logic signed [31:0] r_s;
    logic               r_fin;
    logic               r_last;
    logic [CW-1:0]      r_cnt;
    logic signed [63:0] r_sum;
    logic signed [63:0] r_mean;
    logic signed [63:0] r_m2;
    logic signed [63:0] r_prod;
    logic               r_pstart;
    logic signed [31:0] r_ext;
    logic               r_eseen;
    logic signed [63:0] r_d;
    logic signed [63:0] r_res;
    logic               r_nan;
    logic               r_o_valid;
    logic signed [31:0] r_o_val;
    logic               r_o_nan;

    ssr_pkg::t_div_req  div_req;
    ssr_pkg::t_mul_req  mul_req;
    ssr_pkg::t_sqrt_req sqrt_req;
    ssr_pkg::t_unit_rsp div_rsp;
    ssr_pkg::t_unit_rsp mul_rsp;
    ssr_pkg::t_sqrt_rsp sqrt_rsp;

    logic               in_beat;
    logic               out_free;
    logic               usable;
    logic [31:0]        s_mag;
    logic signed [63:0] s_ext;
    logic signed [63:0] sx;
    logic signed [63:0] d_new;
    logic signed [63:0] d2;
    logic signed [63:0] m2_clip;
    logic signed [31:0] cand;
    logic [31:0]        cand_mag;
    logic [31:0]        ext_mag;
    logic               take;
    logic signed [31:0] res_sat;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(ssr_pkg::S64_MAX)) begin
            return ssr_pkg::S64_MAX;
        end
        if (s < -65'(ssr_pkg::S64_MAX)) begin
            return -ssr_pkg::S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;
    assign usable   = r_fin && (r_stat <= ssr_pkg::STAT_MAGMAX)
                      && (r_cnt < CW'(ssr_pkg::MAX_COUNT));
    assign s_mag    = r_s[31] ? 32'(-r_s) : 32'(r_s);
    assign s_ext    = 64'(r_s);
    assign sx       = {{(64 - 32 - ssr_pkg::MEAN_GUARD){r_s[31]}}, r_s,
                       {ssr_pkg::MEAN_GUARD{1'b0}}};
    assign d_new    = sx - r_mean;
    assign d2       = sx - r_mean;
    assign m2_clip  = r_m2[63] ? 64'sd0 : r_m2;

    // extremes
    always_comb begin
        cand = r_s;
        if (r_stat == ssr_pkg::STAT_ABSMAX && r_s[31]) begin
            cand = (r_s == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_s;
        end
        cand_mag = cand[31] ? 32'(-cand) : 32'(cand);
        ext_mag  = r_ext[31] ? 32'(-r_ext) : 32'(r_ext);
        priority if (!r_eseen) begin
            take = 1'b1;
        end else if (r_stat == ssr_pkg::STAT_MIN) begin
            take = cand < r_ext;
        end else if (r_stat == ssr_pkg::STAT_MAGMAX) begin
            take = cand_mag > ext_mag;
        end else begin
            take = cand > r_ext;
        end
    end

    always_comb begin
        if (r_res > 64'sd2147483647) begin
            res_sat = 32'sh7FFF_FFFF;
        end else if (r_res < -64'sd2147483648) begin
            res_sat = 32'sh8000_0000;
        end else begin
            res_sat = r_res[31:0];
        end
    end

    // unit requests
    always_comb begin
        div_req  = '0;
        mul_req  = '0;
        sqrt_req = '0;
        unique case (r_state)
            ST_UPD: begin
                if (usable) begin
                    if (r_stat == ssr_pkg::STAT_PRODUCT && r_pstart) begin
                        mul_req.start = 1'b1;
                        mul_req.a_mag = mag64(r_prod);
                        mul_req.b_mag = 64'(s_mag);
                        mul_req.shift = ssr_pkg::SH_FRAC;
                        mul_req.neg   = r_prod[63] ^ r_s[31];
                    end else if (r_stat == ssr_pkg::STAT_RMS
                                 || r_stat == ssr_pkg::STAT_NORM) begin
                        mul_req.start = 1'b1;
                        mul_req.a_mag = 64'(s_mag);
                        mul_req.b_mag = 64'(s_mag);
                        mul_req.shift = ssr_pkg::SH_NONE;
                    end else if (r_stat == ssr_pkg::STAT_VAR
                                 || r_stat == ssr_pkg::STAT_STD) begin
                        div_req.start   = 1'b1;
                        div_req.num_mag = mag64(d_new);
                        div_req.den     = 33'(r_cnt) + 33'd1;
                        div_req.neg     = d_new[63];
                    end
                end
            end
            ST_WSTART: begin
                mul_req.start = 1'b1;
                mul_req.a_mag = mag64(r_d);
                mul_req.b_mag = mag64(d2);
                mul_req.shift = ssr_pkg::SH_WIDE;
                mul_req.neg   = r_d[63] ^ d2[63];
            end
            ST_FIN: begin
                if (r_last) begin
                    unique case (r_stat)
                        ssr_pkg::STAT_MEAN, ssr_pkg::STAT_RMS: begin
                            div_req.start   = (r_cnt != '0);
                            div_req.num_mag = mag64(r_sum);
                            div_req.den     = 33'(r_cnt);
                            div_req.neg     = r_sum[63];
                        end
                        ssr_pkg::STAT_NORM: begin
                            sqrt_req.start = (r_cnt != '0);
                            sqrt_req.x     = r_sum;
                        end
                        ssr_pkg::STAT_VAR: begin
                            div_req.start   = (r_cnt >= CW'(2));
                            div_req.num_mag = m2_clip;
                            div_req.den     = 33'(r_cnt - CW'(1)) << ssr_pkg::FRAC_BITS;
                        end
                        ssr_pkg::STAT_STD: begin
                            div_req.start   = (r_cnt >= CW'(2));
                            div_req.num_mag = m2_clip;
                            div_req.den     = 33'(r_cnt - CW'(1));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FDIV: begin
                if (div_rsp.done && (r_stat == ssr_pkg::STAT_RMS
                                     || r_stat == ssr_pkg::STAT_STD)) begin
                    sqrt_req.start = 1'b1;
                    sqrt_req.x     = div_rsp.value;
                end
            end
            default: begin
            end
        endcase
    end

    ssr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ssr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    ssr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    // sequencer and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat    <= ssr_pkg::STAT_MEAN;
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_mean    <= '0;
            r_m2      <= '0;
            r_prod    <= '0;
            r_pstart  <= 1'b0;
            r_ext     <= '0;
            r_eseen   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stat <= i_cfg_wdata;
            end
            if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_s     <= i_in.sample;
                        r_fin   <= i_in.sample_finite;
                        r_last  <= i_in.last_sample;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_state <= ST_FIN;
                    if (usable) begin
                        r_cnt <= r_cnt + CW'(1);
                        unique case (r_stat)
                            ssr_pkg::STAT_MEAN, ssr_pkg::STAT_SUM: begin
                                r_sum <= sat_add(r_sum, s_ext);
                            end
                            ssr_pkg::STAT_PRODUCT: begin
                                if (r_pstart) begin
                                    r_state <= ST_PROD;
                                end else begin
                                    r_prod   <= s_ext;
                                    r_pstart <= 1'b1;
                                end
                            end
                            ssr_pkg::STAT_RMS, ssr_pkg::STAT_NORM: begin
                                r_state <= ST_SQS;
                            end
                            ssr_pkg::STAT_VAR, ssr_pkg::STAT_STD: begin
                                r_d     <= d_new;
                                r_state <= ST_WDIV;
                            end
                            default: begin
                                if (take) begin
                                    r_ext   <= cand;
                                    r_eseen <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_PROD: begin
                    if (mul_rsp.done) begin
                        r_prod  <= mul_rsp.value;
                        r_state <= ST_FIN;
                    end
                end
                ST_SQS: begin
                    if (mul_rsp.done) begin
                        r_sum   <= sat_add(r_sum, mul_rsp.value);
                        r_state <= ST_FIN;
                    end
                end
                ST_WDIV: begin
                    if (div_rsp.done) begin
                        r_mean  <= r_mean + div_rsp.value;
                        r_state <= ST_WSTART;
                    end
                end
                ST_WSTART: begin
                    r_state <= ST_WMUL;
                end
                ST_WMUL: begin
                    if (mul_rsp.done) begin
                        r_m2    <= sat_add(r_m2, mul_rsp.value);
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_nan   <= 1'b0;
                        r_res   <= '0;
                        r_state <= ST_OUT;
                        unique case (r_stat)
                            ssr_pkg::STAT_MEAN, ssr_pkg::STAT_RMS: begin
                                if (r_cnt == '0) begin
                                    r_nan <= 1'b1;
                                end else begin
                                    r_state <= ST_FDIV;
                                end
                            end
                            ssr_pkg::STAT_SUM: begin
                                r_res <= r_sum;
                            end
                            ssr_pkg::STAT_PRODUCT: begin
                                r_nan <= !r_pstart;
                                r_res <= r_prod;
                            end
                            ssr_pkg::STAT_NORM: begin
                                if (r_cnt == '0) begin
                                    r_nan <= 1'b1;
                                end else begin
                                    r_state <= ST_FSQRT;
                                end
                            end
                            ssr_pkg::STAT_VAR, ssr_pkg::STAT_STD: begin
                                if (r_cnt < CW'(2)) begin
                                    r_nan <= 1'b1;
                                end else begin
                                    r_state <= ST_FDIV;
                                end
                            end
                            ssr_pkg::STAT_MIN, ssr_pkg::STAT_MAX,
                            ssr_pkg::STAT_ABSMAX, ssr_pkg::STAT_MAGMAX: begin
                                r_nan <= !r_eseen;
                                r_res <= 64'(r_ext);
                            end
                            default: begin
                                r_nan <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_FDIV: begin
                    if (div_rsp.done) begin
                        if (r_stat == ssr_pkg::STAT_RMS || r_stat == ssr_pkg::STAT_STD) begin
                            r_state <= ST_FSQRT;
                        end else begin
                            r_res   <= div_rsp.value;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_FSQRT: begin
                    if (sqrt_rsp.done) begin
                        r_res   <= 64'(sqrt_rsp.root);
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_val   <= r_nan ? 32'sd0 : res_sat;
                        r_o_nan   <= r_nan;
                        r_cnt     <= '0;
                        r_sum     <= '0;
                        r_mean    <= '0;
                        r_m2      <= '0;
                        r_prod    <= '0;
                        r_pstart  <= 1'b0;
                        r_ext     <= '0;
                        r_eseen   <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.result_value  = r_o_val;
    assign o_out.result_is_nan = r_o_nan;

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ssr_pkg::MAX_COUNT))
        else $error("sample count beyond limit");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({div_req.start, mul_req.start, sqrt_req.start}))
        else $error("two arithmetic units started together");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=>
            (r_cnt == '0 && !r_pstart && !r_eseen && o_out.valid))
        else $error("state not cleared after result beat");
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// self-checking testbench for the streaming statistic reducer top level
`default_nettype none
module tb_top;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    // any code above the last defined statistic
    localparam logic [3:0] STAT_UNKNOWN = 4'd15;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               finite;
        logic               last;
    } t_sample_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_nan;
    } t_stat_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;

    ssr_in_if  in_ch ();
    ssr_out_if out_ch ();

    streaming_statistic_reducer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_sample_beat pending_beats[$];
    t_stat_result expected_results[$];
    int  send_idle_pct = 21;
    int  recv_stall_pct = 71;
    int  fail_count = 0;
    int  quiet_cycles = 0;
    logic beat_taken = 1'b0;

    // predictor state
    logic [3:0]         p_stat;
    logic [31:0]        p_count;
    logic signed [63:0] p_sum, p_mean, p_m2, p_prod;
    logic               p_prod_started, p_ext_seen;
    logic signed [31:0] p_ext;

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        if (b > 0 && a > ssr_pkg::S64_MAX - b) return ssr_pkg::S64_MAX;
        if (b < 0 && a < -ssr_pkg::S64_MAX - b) return -ssr_pkg::S64_MAX;
        return a + b;
    endfunction

    function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
        r = (p[127:64] != 0 || p[63:0] > ssr_pkg::S64_MAX) ? ssr_pkg::S64_MAX : p[63:0];
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] div_near(input logic signed [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] q;
        q = (mag(num) + den / 2) / den;
        if (q > ssr_pkg::S64_MAX) q = ssr_pkg::S64_MAX;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] sqrt_near(input logic [63:0] x);
        logic [63:0] r, b, v;
        r = 0;
        b = 64'd1 << 62;
        v = x;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (x - r * r > r) r = r + 1;
        return r;
    endfunction

    task automatic clear_accumulators();
        p_count = 0; p_sum = 0; p_mean = 0; p_m2 = 0; p_prod = 0;
        p_prod_started = 0; p_ext = 0; p_ext_seen = 0;
    endtask

    task automatic absorb_sample(input logic signed [63:0] s);
        logic signed [63:0] sx, d, d2, cand;
        logic take;
        p_count = p_count + 1;
        case (p_stat)
            ssr_pkg::STAT_MEAN, ssr_pkg::STAT_SUM: p_sum = add_sat(p_sum, s);
            ssr_pkg::STAT_PRODUCT: begin
                p_prod = p_prod_started ? mul_round(p_prod, s, ssr_pkg::FRAC_BITS) : s;
                p_prod_started = 1;
            end
            ssr_pkg::STAT_RMS, ssr_pkg::STAT_NORM: p_sum = add_sat(p_sum, mag(s) * mag(s));
            ssr_pkg::STAT_VAR, ssr_pkg::STAT_STD: begin
                sx = s <<< ssr_pkg::MEAN_GUARD;
                d = sx - p_mean;
                p_mean = p_mean + div_near(d, p_count);
                d2 = sx - p_mean;
                p_m2 = add_sat(p_m2, mul_round(d, d2, 2 * ssr_pkg::MEAN_GUARD));
            end
            default: begin
                cand = s;
                if (p_stat == ssr_pkg::STAT_ABSMAX && s < 0) cand = (s < -64'sd2147483647) ?
                    64'sd2147483647 : -s;
                if (!p_ext_seen) take = 1;
                else if (p_stat == ssr_pkg::STAT_MIN) take = cand < p_ext;
                else if (p_stat == ssr_pkg::STAT_MAGMAX) take = mag(cand) > mag(p_ext);
                else take = cand > p_ext;
                if (take) begin
                    p_ext = cand[31:0];
                    p_ext_seen = 1;
                end
            end
        endcase
    endtask

    task automatic predict_beat(input t_sample_beat bt);
        logic signed [63:0] v, m2;
        t_stat_result r;
        logic nan;
        v = 0;
        nan = 0;
        if (bt.finite && p_stat <= ssr_pkg::STAT_MAGMAX && p_count < ssr_pkg::MAX_COUNT)
            absorb_sample(bt.sample);
        if (bt.last) begin
            m2 = p_m2 < 0 ? 0 : p_m2;
            case (p_stat)
                ssr_pkg::STAT_MEAN: if (p_count == 0) nan = 1;
                    else v = div_near(p_sum, p_count);
                ssr_pkg::STAT_SUM: v = p_sum;
                ssr_pkg::STAT_PRODUCT: if (!p_prod_started) nan = 1; else v = p_prod;
                ssr_pkg::STAT_RMS: if (p_count == 0) nan = 1;
                    else v = sqrt_near(div_near(p_sum, p_count));
                ssr_pkg::STAT_NORM: if (p_count == 0) nan = 1; else v = sqrt_near(p_sum);
                ssr_pkg::STAT_VAR: if (p_count < 2) nan = 1;
                    else v = div_near(m2, 64'(p_count - 1) << ssr_pkg::FRAC_BITS);
                ssr_pkg::STAT_STD: if (p_count < 2) nan = 1;
                    else v = sqrt_near(div_near(m2, p_count - 1));
                ssr_pkg::STAT_MIN, ssr_pkg::STAT_MAX,
                ssr_pkg::STAT_ABSMAX, ssr_pkg::STAT_MAGMAX:
                    if (!p_ext_seen) nan = 1; else v = p_ext;
                default: nan = 1;
            endcase
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.value = nan ? 32'sd0 : v[31:0];
            r.is_nan = nan;
            expected_results.insert(expected_results.size(), r);
            clear_accumulators();
        end
    endtask

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_stat_result want;
        if (!i_rst_n) begin
            p_stat = ssr_pkg::STAT_MEAN;
            clear_accumulators();
            beat_taken <= 1'b0;
        end else begin
            if (cfg_we) p_stat = cfg_wdata;
            beat_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                predict_beat(t_sample_beat'{in_ch.sample, in_ch.sample_finite,
                                            in_ch.last_sample});
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat value %0d nan %0b",
                           out_ch.result_value, out_ch.result_is_nan);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.result_is_nan !== want.is_nan) begin
                        $error("result_is_nan expected %0b actual %0b",
                               want.is_nan, out_ch.result_is_nan);
                        fail_count++;
                    end
                    if (out_ch.result_value !== want.value) begin
                        $error("result_value expected %0d actual %0d",
                               want.value, out_ch.result_value);
                        fail_count++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else if (pending_beats.size() != 0 || expected_results.size() != 0 || in_ch.valid)
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("streaming_statistic_reducer_top test failed");
                $finish;
            end
        end
    end

    // driver and receiver stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || beat_taken) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    {in_ch.sample, in_ch.sample_finite, in_ch.last_sample}
                        <= pending_beats.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_beat(input logic [31:0] s, input logic f, input logic l);
        pending_beats.insert(pending_beats.size(), t_sample_beat'{s, f, l});
    endtask

    task automatic write_statistic(input logic [3:0] code);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= code;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every beat has gone in and every result has come out
    task automatic drain();
        while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8)) - 4) <<< 16;
            2: return $signed($urandom_range(2000)) - 1000;
            3: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'h0001_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(32'h0004_0000))) - 32'sh0002_0000;
        endcase
    endfunction

    initial begin
        int total;
        int len;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.sample_finite = 1'b0;
        in_ch.last_sample = 1'b0;
        out_ch.ready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty traversal under the reset setting, then extremes
        queue_beat(32'h0001_0000, 1'b0, 1'b1);
        drain();
        write_statistic(ssr_pkg::STAT_SUM);
        queue_beat(32'd5, 1'b0, 1'b1);
        queue_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b1, 1'b1);
        drain();
        write_statistic(ssr_pkg::STAT_VAR);
        queue_beat(32'h0003_0000, 1'b1, 1'b1);
        queue_beat(32'h8000_0000, 1'b1, 1'b0);
        queue_beat(32'h7FFF_FFFF, 1'b1, 1'b1);
        drain();
        write_statistic(ssr_pkg::STAT_PRODUCT);
        queue_beat(32'h8000_0000, 1'b1, 1'b0);
        queue_beat(32'h8000_0000, 1'b1, 1'b1);
        queue_beat(32'h0, 1'b0, 1'b1);
        drain();
        write_statistic(ssr_pkg::STAT_ABSMAX);
        queue_beat(32'h8000_0000, 1'b1, 1'b1);
        drain();
        write_statistic(ssr_pkg::STAT_MAGMAX);
        // equal magnitude keeps the earlier sample
        queue_beat(-32'sd5, 1'b1, 1'b0);
        queue_beat(32'd5, 1'b1, 1'b1);
        drain();
        write_statistic(ssr_pkg::STAT_STD);
        queue_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_beat(32'h8000_0000, 1'b1, 1'b0);
        queue_beat(32'h0001_0000, 1'b1, 1'b1);
        drain();
        write_statistic(STAT_UNKNOWN);
        queue_beat(32'h0001_0000, 1'b1, 1'b1);
        drain();

        total = 0;
        while (total < 1150) begin
            if (total >= 770) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (total >= 385) begin
                send_idle_pct = 71;
                recv_stall_pct = 21;
            end
            write_statistic(($urandom_range(9) == 0) ? 4'($urandom_range(15, 11))
                                                      : 4'($urandom_range(10)));
            repeat ($urandom_range(6, 2)) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                for (int k = 0; k < len; k++) begin
                    queue_beat(pick_sample(), $urandom_range(9) != 0, k == len - 1);
                    total++;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("streaming_statistic_reducer_top test passed");
        end else begin
            $display("streaming_statistic_reducer_top test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
